// ===== rtl/afk_pkg.sv =====
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and constant tables of the arm forward kinematics
// unit: Q28 formats, link transforms, arctangent function and pose records.
// ----------------------------------------------------------------------------
package afk_pkg;

	// default build settings
	localparam int ANGLE_FRAC_BITS_DEF = 12;
	localparam int TRIG_ITERATIONS_DEF = 16;
	localparam int ARM_JOINTS          = 4;
	localparam int LINKS               = ARM_JOINTS + 1;

	// internal fixed point
	localparam int QB       = 28;
	localparam int ENT_W    = 32;
	localparam int POS_W    = 36;
	localparam int LINK_LAT = 4;

	localparam longint HALF_PI_Q       = 64'sd421657428;
	localparam longint QUARTER_PI_Q    = 64'sd210828714;
	localparam longint INV_GAIN_Q      = 64'sd163008218;
	localparam longint GRIP_CLOSED_MAG = 64'sd462514291;
	localparam longint GRIP_OFFSET_Z   = 64'sd9932112;
	localparam longint ROUND_Q         = 64'sd1 <<< (QB - 1);

	// reciprocal of a quarter turn, applied to the angle shifted down by 20
	localparam int     RECIP_PRE   = 20;
	localparam int     RECIP_POST  = 24;
	localparam longint RECIP_HALF_PI =
		((64'sd1 <<< (RECIP_PRE + RECIP_POST)) + HALF_PI_Q / 2) / HALF_PI_Q;

	// origin rotations of each link (signed permutations), last is the gripper
	localparam int ROT_TAB [LINKS][3][3] = '{
		'{'{-1, 0, 0}, '{0, 0, -1}, '{0, -1, 0}},
		'{'{-1, 0, 0}, '{0, -1, 0}, '{0, 0, 1}},
		'{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}},
		'{'{0, 1, 0}, '{0, 0, -1}, '{-1, 0, 0}},
		'{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}}
	};

	// origin offsets of each link in Q28 metres
	localparam longint OFF_TAB [LINKS][3] = '{
		'{64'sd0, 64'sd53687, -64'sd40345849},
		'{-64'sd11067594, 64'sd62115965, -64'sd134218},
		'{-64'sd11000485, -64'sd72101763, 64'sd0},
		'{64'sd0, -64'sd13929116, 64'sd0},
		'{64'sd0, 64'sd0, GRIP_OFFSET_Z}
	};

	typedef logic signed [ENT_W-1:0] ent_t;
	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		ent_t [2:0][2:0] r;
		pos_t [2:0]      t;
	} pose_t;

	typedef struct packed {
		ent_t c;
		ent_t s;
	} trig_t;

	// arctangent of 2^-i in Q28 from its power series, long division by bits
	function automatic longint afk_atan(int i);
		longint sum;
		longint term;
		longint rem;
		int     m;
		int     d;
		int     k;
		int     b;
		sum = 0;
		if (i == 0) begin
			return QUARTER_PI_Q;
		end
		for (k = 0; i * (2 * k + 1) <= 60; k++) begin
			m    = 60 - i * (2 * k + 1);
			d    = 2 * k + 1;
			term = 0;
			rem  = 0;
			for (b = m; b >= 0; b--) begin
				rem  = (rem <<< 1) + ((b == m) ? 64'sd1 : 64'sd0);
				term = term <<< 1;
				if (rem >= longint'(d)) begin
					rem  = rem - longint'(d);
					term = term + 64'sd1;
				end
			end
			if ((k % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return (sum + (64'sd1 <<< 31)) >>> 32;
	endfunction

endpackage

// ===== rtl/afk_sincos.sv =====
// ----------------------------------------------------------------------------
// afk_sincos
// Pipelined cosine and sine of a Q28 angle: quarter-turn reduction over three
// stages, one CORDIC step per stage, then quadrant mapping.
// ----------------------------------------------------------------------------
module afk_sincos #(
	parameter int ANGLE_W         = 34,
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_i,
	input  logic signed [ANGLE_W-1:0] angle_i,
	output logic                      valid_o,
	output afk_pkg::trig_t            trig_o
);
	import afk_pkg::*;

	localparam int NW = ANGLE_W + 1;
	localparam int QW = NW - 27;
	localparam int RW = 34;

	// reduction stage one: add an eighth turn, estimate the quadrant count
	logic signed [NW-1:0] n_c;
	logic signed [NW-1:0] nhi_c;
	logic signed [63:0]   qprod_c;
	logic signed [63:0]   qsh_c;
	logic signed [NW-1:0] n_s1;
	logic signed [QW-1:0] qe_s1;
	logic                 valid_s1;

	always_comb begin
		n_c     = NW'(angle_i) + NW'(QUARTER_PI_Q);
		nhi_c   = n_c >>> RECIP_PRE;
		qprod_c = longint'(nhi_c) * RECIP_HALF_PI;
		qsh_c   = qprod_c >>> RECIP_POST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		n_s1  <= n_c;
		qe_s1 <= qsh_c[QW-1:0];
	end

	// reduction stage two: remainder against the estimate
	logic signed [63:0]   rr_c;
	logic signed [RW-1:0] r_s2;
	logic [1:0]           q_s2;
	logic                 valid_s2;

	assign rr_c = longint'(n_s1) - longint'(qe_s1) * HALF_PI_Q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= rr_c[RW-1:0];
		q_s2 <= qe_s1[1:0];
	end

	// reduction stage three: correct the estimate by one either way
	logic signed [RW-1:0] z_c;
	logic [1:0]           q_c;

	always_comb begin
		if (r_s2 < 0) begin
			z_c = r_s2 + RW'(HALF_PI_Q) - RW'(QUARTER_PI_Q);
			q_c = q_s2 - 2'd1;
		end else if (r_s2 >= RW'(HALF_PI_Q)) begin
			z_c = r_s2 - RW'(HALF_PI_Q) - RW'(QUARTER_PI_Q);
			q_c = q_s2 + 2'd1;
		end else begin
			z_c = r_s2 - RW'(QUARTER_PI_Q);
			q_c = q_s2;
		end
	end

	// cordic pipeline, index 0 loaded by the last reduction stage
	ent_t       cx_s [TRIG_ITERATIONS+1];
	ent_t       cy_s [TRIG_ITERATIONS+1];
	ent_t       cz_s [TRIG_ITERATIONS+1];
	logic [1:0] cq_s [TRIG_ITERATIONS+1];
	logic       cv_s [TRIG_ITERATIONS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else begin
			cv_s[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0] <= ENT_W'(INV_GAIN_Q);
		cy_s[0] <= '0;
		cz_s[0] <= z_c[ENT_W-1:0];
		cq_s[0] <= q_c;
	end

	for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_cordic
		localparam longint AT_L = afk_atan(g);
		localparam ent_t   AT   = AT_L[ENT_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[g+1] <= 1'b0;
			end else begin
				cv_s[g+1] <= cv_s[g];
			end
		end

		// one micro-rotation toward zero residual angle
		always_ff @(posedge clk) begin
			if (cz_s[g] >= 0) begin
				cx_s[g+1] <= cx_s[g] - (cy_s[g] >>> g);
				cy_s[g+1] <= cy_s[g] + (cx_s[g] >>> g);
				cz_s[g+1] <= cz_s[g] - AT;
			end else begin
				cx_s[g+1] <= cx_s[g] + (cy_s[g] >>> g);
				cy_s[g+1] <= cy_s[g] - (cx_s[g] >>> g);
				cz_s[g+1] <= cz_s[g] + AT;
			end
			cq_s[g+1] <= cq_s[g];
		end
	end

	// quadrant mapping
	trig_t tq_c;
	ent_t  xf;
	ent_t  yf;

	assign xf = cx_s[TRIG_ITERATIONS];
	assign yf = cy_s[TRIG_ITERATIONS];

	always_comb begin
		unique case (cq_s[TRIG_ITERATIONS])
			2'd0: begin
				tq_c.c = xf;
				tq_c.s = yf;
			end
			2'd1: begin
				tq_c.c = -yf;
				tq_c.s = xf;
			end
			2'd2: begin
				tq_c.c = -xf;
				tq_c.s = -yf;
			end
			default: begin
				tq_c.c = yf;
				tq_c.s = -xf;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= cv_s[TRIG_ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		trig_o <= tq_c;
	end

endmodule

// ===== rtl/afk_link.sv =====
// ----------------------------------------------------------------------------
// afk_link
// One link of the chain in four stages: origin permutation and offset
// products, offset sum, joint rotation products, rotation sums.
// ----------------------------------------------------------------------------
module afk_link #(
	parameter int LINK = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  afk_pkg::pose_t pose_i,
	input  afk_pkg::trig_t trig_i,
	output logic           valid_o,
	output afk_pkg::pose_t pose_o
);
	import afk_pkg::*;

	// unpack the incoming pose
	ent_t r_in [3][3];
	pos_t t_in [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				r_in[i][j] = pose_i.r[i][j];
			end
			t_in[i] = pose_i.t[i];
		end
	end

	// stage one: permuted rotation and offset products
	ent_t               rp_c  [3][3];
	logic signed [63:0] prd_c [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rp_c[i][j] = '0;
				for (int k = 0; k < 3; k++) begin
					if (ROT_TAB[LINK][k][j] == 1) begin
						rp_c[i][j] = rp_c[i][j] + r_in[i][k];
					end else if (ROT_TAB[LINK][k][j] == -1) begin
						rp_c[i][j] = rp_c[i][j] - r_in[i][k];
					end
				end
				prd_c[i][j] = longint'(r_in[i][j]) * OFF_TAB[LINK][j];
			end
		end
	end

	ent_t               r_s1   [3][3];
	logic signed [63:0] prd_s1 [3][3];
	pos_t               t_s1   [3];
	trig_t              trig_s1;
	logic               valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		r_s1    <= rp_c;
		prd_s1  <= prd_c;
		t_s1    <= t_in;
		trig_s1 <= trig_i;
	end

	// stage two: round the offset sum into the translation
	logic signed [63:0] acc_c [3];
	logic signed [63:0] accs_c [3];
	ent_t               r_s2 [3][3];
	pos_t               t_s2 [3];
	trig_t              trig_s2;
	logic               valid_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_c[i]  = prd_s1[i][0] + prd_s1[i][1] + prd_s1[i][2] + ROUND_Q;
			accs_c[i] = acc_c[i] >>> QB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t_s2[i] <= t_s1[i] + accs_c[i][POS_W-1:0];
		end
		r_s2    <= r_s1;
		trig_s2 <= trig_s1;
	end

	// stage three: products with cosine and sine
	logic signed [63:0] m_s3 [3][4];
	ent_t               r2_s3 [3];
	pos_t               t_s3 [3];
	logic               valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			m_s3[i][0] <= longint'(r_s2[i][0]) * longint'(trig_s2.c);
			m_s3[i][1] <= longint'(r_s2[i][1]) * longint'(trig_s2.s);
			m_s3[i][2] <= longint'(r_s2[i][0]) * longint'(trig_s2.s);
			m_s3[i][3] <= longint'(r_s2[i][1]) * longint'(trig_s2.c);
			r2_s3[i]   <= r_s2[i][2];
		end
		t_s3 <= t_s2;
	end

	// stage four: rounded rotation sums
	logic signed [63:0] n0_c [3];
	logic signed [63:0] n1_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n0_c[i] = (m_s3[i][0] + m_s3[i][1] + ROUND_Q) >>> QB;
			n1_c[i] = (m_s3[i][3] - m_s3[i][2] + ROUND_Q) >>> QB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pose_o.r[i][0] <= n0_c[i][ENT_W-1:0];
			pose_o.r[i][1] <= n1_c[i][ENT_W-1:0];
			pose_o.r[i][2] <= r2_s3[i];
			pose_o.t[i]    <= t_s3[i];
		end
	end

endmodule

// ===== rtl/arm_forward_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// arm_forward_kinematics_unit
// End link pose of a four-joint arm with gripper joint: rotation in Q1.14
// and position in 2^-16 m from four joint angles and a gripper opening.
// ----------------------------------------------------------------------------
// channel   direction  signals                               handshake
// command   in         joint_angle_1..4, gripper_opening     start, busy
// result    out        rot_00..rot_22, pos_x, pos_y, pos_z   done
//
// one item enters every cycle; busy is always low
// the pipeline is the input register, angle reduction and one cordic step
// per stage, the quadrant mapping register, four stages per link over five
// links, output rounding
// reset clears only the valid bits; pipeline data is not reset
// each result is shown on done for one cycle and cannot be held off
// ----------------------------------------------------------------------------
module arm_forward_kinematics_unit #(
	parameter int ANGLE_FRAC_BITS = afk_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = afk_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] joint_angle_1,
	input  logic signed [15:0] joint_angle_2,
	input  logic signed [15:0] joint_angle_3,
	input  logic signed [15:0] joint_angle_4,
	input  logic signed [16:0] gripper_opening,
	output logic               done,
	output logic signed [15:0] rot_00,
	output logic signed [15:0] rot_01,
	output logic signed [15:0] rot_02,
	output logic signed [15:0] rot_10,
	output logic signed [15:0] rot_11,
	output logic signed [15:0] rot_12,
	output logic signed [15:0] rot_20,
	output logic signed [15:0] rot_21,
	output logic signed [15:0] rot_22,
	output logic signed [19:0] pos_x,
	output logic signed [19:0] pos_y,
	output logic signed [19:0] pos_z
);
	import afk_pkg::*;

	localparam int ANGLE_W = (44 - ANGLE_FRAC_BITS > 30) ? 46 - ANGLE_FRAC_BITS : 32;
	localparam int LAT     = TRIG_ITERATIONS + 26;

	assign busy = 1'b0;

	// input stage: joint angles to Q28, gripper opening to its angle
	logic signed [16:0]        open_cl_c;
	logic [15:0]               shut_c;
	logic signed [63:0]        gprod_c;
	logic signed [63:0]        gang_c;
	logic signed [15:0]        jin_c [ARM_JOINTS];
	logic signed [ANGLE_W-1:0] ang_s0 [LINKS];
	logic                      valid_s0;

	assign jin_c[0] = joint_angle_1;
	assign jin_c[1] = joint_angle_2;
	assign jin_c[2] = joint_angle_3;
	assign jin_c[3] = joint_angle_4;

	always_comb begin
		if (gripper_opening < 0) begin
			open_cl_c = '0;
		end else if (gripper_opening > 17'sd32768) begin
			open_cl_c = 17'sd32768;
		end else begin
			open_cl_c = gripper_opening;
		end
		shut_c  = 16'(17'sd32768 - open_cl_c);
		gprod_c = GRIP_CLOSED_MAG * longint'({1'b0, shut_c});
		gang_c  = -((gprod_c + 64'sd16384) >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ARM_JOINTS; j++) begin
			ang_s0[j] <= ANGLE_W'(jin_c[j]) <<< (QB - ANGLE_FRAC_BITS);
		end
		ang_s0[ARM_JOINTS] <= gang_c[ANGLE_W-1:0];
	end

	// five sine and cosine pipelines in parallel
	trig_t       trig_sc [LINKS];
	logic [LINKS-1:0] sc_valid;

	for (genvar g = 0; g < LINKS; g++) begin : g_trig
		afk_sincos #(
			.ANGLE_W         (ANGLE_W),
			.TRIG_ITERATIONS (TRIG_ITERATIONS)
		) u_sincos (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_s0),
			.angle_i (ang_s0[g]),
			.valid_o (sc_valid[g]),
			.trig_o  (trig_sc[g])
		);
	end

	// link chain, each link's trig delayed to meet its pose
	pose_t       pose_l  [LINKS+1];
	logic        valid_l [LINKS+1];
	trig_t       trig_l  [LINKS];
	pose_t       pose_id;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pose_id.r[i][j] = (i == j) ? ENT_W'(64'sd1 <<< QB) : '0;
			end
			pose_id.t[i] = '0;
		end
	end

	assign pose_l[0]  = pose_id;
	assign valid_l[0] = &sc_valid;

	for (genvar g = 0; g < LINKS; g++) begin : g_link
		if (g == 0) begin : g_nodly
			assign trig_l[g] = trig_sc[g];
		end else begin : g_dly
			trig_t dly_q [LINK_LAT*g];
			always_ff @(posedge clk) begin
				dly_q[0] <= trig_sc[g];
				for (int d = 1; d < LINK_LAT * g; d++) begin
					dly_q[d] <= dly_q[d-1];
				end
			end
			assign trig_l[g] = dly_q[LINK_LAT*g-1];
		end

		afk_link #(
			.LINK (g)
		) u_link (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_l[g]),
			.pose_i  (pose_l[g]),
			.trig_i  (trig_l[g]),
			.valid_o (valid_l[g+1]),
			.pose_o  (pose_l[g+1])
		);
	end

	// output rounding and saturation
	function automatic logic signed [15:0] sat_rot(ent_t v);
		ent_t w;
		w = (v + ENT_W'(64'sd8192)) >>> 14;
		if (w > ENT_W'(64'sd32767)) begin
			return 16'sh7fff;
		end else if (w < -ENT_W'(64'sd32768)) begin
			return 16'sh8000;
		end
		return w[15:0];
	endfunction

	function automatic logic signed [19:0] sat_pos(pos_t v);
		pos_t w;
		w = (v + POS_W'(64'sd2048)) >>> 12;
		if (w > POS_W'(64'sd524287)) begin
			return 20'sh7ffff;
		end else if (w < -POS_W'(64'sd524288)) begin
			return 20'sh80000;
		end
		return w[19:0];
	endfunction

	pose_t pf;
	assign pf = pose_l[LINKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_l[LINKS];
		end
	end

	always_ff @(posedge clk) begin
		rot_00 <= sat_rot(pf.r[0][0]);
		rot_01 <= sat_rot(pf.r[0][1]);
		rot_02 <= sat_rot(pf.r[0][2]);
		rot_10 <= sat_rot(pf.r[1][0]);
		rot_11 <= sat_rot(pf.r[1][1]);
		rot_12 <= sat_rot(pf.r[1][2]);
		rot_20 <= sat_rot(pf.r[2][0]);
		rot_21 <= sat_rot(pf.r[2][1]);
		rot_22 <= sat_rot(pf.r[2][2]);
		pos_x  <= sat_pos(pf.t[0]);
		pos_y  <= sat_pos(pf.t[1]);
		pos_z  <= sat_pos(pf.t[2]);
	end

	// every result traces back to a command taken a fixed time earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching command");

	// the rot_00 and rot_22 entries of a proper rotation stay near unit size
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rot_00 <= 16'sd17000 && rot_00 >= -16'sd17000 &&
		          rot_22 <= 16'sd17000 && rot_22 >= -16'sd17000))
		else $error("rotation entry out of unit range");

	// reach of the arm bounds the x and z position
	a_pos_reach: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pos_z <= 20'sd131072 && pos_z >= -20'sd131072 &&
		          pos_x <= 20'sd131072 && pos_x >= -20'sd131072))
		else $error("position beyond arm reach");

endmodule

// ===== tb/afk_pose_checker.sv =====
// ----------------------------------------------------------------------------
// afk_pose_checker
// Watches the command and result channels of the arm forward kinematics
// unit, predicts the end link pose of every accepted item and compares each
// result field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module afk_pose_checker #(
	parameter int ANGLE_FRAC_BITS = afk_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = afk_pkg::TRIG_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] joint_angle_1,
	input  logic signed [15:0] joint_angle_2,
	input  logic signed [15:0] joint_angle_3,
	input  logic signed [15:0] joint_angle_4,
	input  logic signed [16:0] gripper_opening,
	input  logic               done,
	input  logic signed [15:0] rot_00,
	input  logic signed [15:0] rot_01,
	input  logic signed [15:0] rot_02,
	input  logic signed [15:0] rot_10,
	input  logic signed [15:0] rot_11,
	input  logic signed [15:0] rot_12,
	input  logic signed [15:0] rot_20,
	input  logic signed [15:0] rot_21,
	input  logic signed [15:0] rot_22,
	input  logic signed [19:0] pos_x,
	input  logic signed [19:0] pos_y,
	input  logic signed [19:0] pos_z,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import afk_pkg::*;

	localparam longint ONE_Q = 64'sd1 <<< QB;

	typedef struct {
		longint r[3][3];
		longint t[3];
	} frame_t;

	typedef struct {
		longint v[12];
	} pose_fields_t;

	pose_fields_t pose_q[$];

	string field_name[12] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11",
		"rot_12", "rot_20", "rot_21", "rot_22", "pos_x", "pos_y", "pos_z"};

	// arctangent of 2^-i in Q28 from the alternating power series
	function automatic longint atan_q(int i);
		longint acc;
		int     k;
		acc = 0;
		if (i == 0) begin
			return QUARTER_PI_Q;
		end
		for (k = 0; i * (2 * k + 1) <= 60; k++) begin
			if (k % 2) begin
				acc -= (64'sd1 <<< (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
			end else begin
				acc += (64'sd1 <<< (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
			end
		end
		return (acc + (64'sd1 <<< 31)) >>> 32;
	endfunction

	// frame product p * a with Q28 rounding
	function automatic frame_t chain(frame_t p, frame_t a);
		frame_t o;
		longint sm;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sm = 0;
				for (int k = 0; k < 3; k++) sm += p.r[i][k] * a.r[k][j];
				o.r[i][j] = (sm + ROUND_Q) >>> QB;
			end
			sm = 0;
			for (int k = 0; k < 3; k++) sm += p.r[i][k] * a.t[k];
			o.t[i] = p.t[i] + ((sm + ROUND_Q) >>> QB);
		end
		return o;
	endfunction

	// z rotation by a Q28 angle: quadrant reduction then cordic
	function automatic frame_t spin_z(frame_t p, longint ang);
		frame_t m;
		longint n, q, x, y, z, dx, dy, c, s;
		n = ang + QUARTER_PI_Q;
		q = n / HALF_PI_Q;
		if (n % HALF_PI_Q < 0) q--;
		z = ang - q * HALF_PI_Q;
		x = INV_GAIN_Q;
		y = 0;
		for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_q(i);
			end else begin
				x += dx; y -= dy; z += atan_q(i);
			end
		end
		case (q & 3)
			0: begin c = x;  s = y;  end
			1: begin c = -y; s = x;  end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		foreach (m.r[i, j]) m.r[i][j] = 0;
		m.t = '{0, 0, 0};
		m.r[0][0] = c; m.r[0][1] = -s; m.r[1][0] = s; m.r[1][1] = c; m.r[2][2] = ONE_Q;
		return chain(p, m);
	endfunction

	// round and saturate to a w bit signed field
	function automatic longint clip(longint v, int sh, int w);
		longint r, hi;
		r  = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (r > hi) r = hi;
		if (r < -hi - 1) r = -hi - 1;
		return r;
	endfunction

	// end link pose of one item
	function automatic pose_fields_t end_pose(longint ang[4], longint opening);
		frame_t       p, link;
		pose_fields_t res;
		longint       o;
		foreach (p.r[i, j]) p.r[i][j] = (i == j) ? ONE_Q : 0;
		p.t = '{0, 0, 0};
		for (int n = 0; n < LINKS; n++) begin
			foreach (link.r[i, j]) link.r[i][j] = longint'(ROT_TAB[n][i][j]) * ONE_Q;
			foreach (link.t[i]) link.t[i] = OFF_TAB[n][i];
			p = chain(p, link);
			if (n < ARM_JOINTS) begin
				p = spin_z(p, ang[n] * (64'sd1 <<< (QB - ANGLE_FRAC_BITS)));
			end
		end
		o = opening;
		if (o < 0) o = 0;
		if (o > 32768) o = 32768;
		p = spin_z(p, -((GRIP_CLOSED_MAG * (32768 - o) + 16384) >>> 15));
		foreach (p.r[i, j]) res.v[i * 3 + j] = clip(p.r[i][j], 14, 16);
		foreach (p.t[i]) res.v[9 + i] = clip(p.t[i], 12, 20);
		return res;
	endfunction

	// predict on accepted items, compare on every done strobe
	always @(posedge clk or negedge arst_n) begin
		pose_fields_t want;
		longint       seen[12];
		longint       ang[4];
		int           nerr;
		nerr = 0;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
			pose_q.delete();
		end else begin
			if (done) begin
				seen = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
					rot_20, rot_21, rot_22, pos_x, pos_y, pos_z};
				if (pose_q.size() == 0) begin
					$error("result with no item outstanding");
					nerr++;
				end else begin
					want = pose_q.pop_front();
					foreach (seen[i]) begin
						if (seen[i] != want.v[i]) begin
							$error("%s: expected %0d, got %0d", field_name[i], want.v[i],
								seen[i]);
							nerr++;
						end
					end
				end
			end
			if (start && !busy) begin
				ang = '{joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4};
				pose_q.push_back(end_pose(ang, gripper_opening));
			end
			errors  <= errors + nerr;
			pending <= pose_q.size();
		end
	end

endmodule

// ===== tb/tb_arm_forward_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// tb_arm_forward_kinematics_unit
// Drives directed joint vectors (range extremes, quarter turns, gripper
// clamping) and then random ones with random idle bursts; the pose checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_arm_forward_kinematics_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY     = afk_pkg::TRIG_ITERATIONS_DEF + 26;
	localparam int RAND_ITEMS  = 1800;
	localparam int CYCLE_LIMIT = 200000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] joint_angle_1, joint_angle_2, joint_angle_3, joint_angle_4;
	logic signed [16:0] gripper_opening;
	logic               done;
	logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
	logic signed [15:0] rot_20, rot_21, rot_22;
	logic signed [19:0] pos_x, pos_y, pos_z;
	int                 errors;
	int                 pending;
	int                 cycles = 0;
	int                 sent;

	arm_forward_kinematics_unit u_dut (.*);

	afk_pose_checker u_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_arm_forward_kinematics_unit: done, errors");
			$finish;
		end
	end

	// present one item and hold it until accepted
	task automatic send_item(logic signed [15:0] a1, logic signed [15:0] a2,
		logic signed [15:0] a3, logic signed [15:0] a4, logic signed [16:0] op);
		start           <= 1'b1;
		joint_angle_1   <= a1;
		joint_angle_2   <= a2;
		joint_angle_3   <= a3;
		joint_angle_4   <= a4;
		gripper_opening <= op;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// random angle: mostly within a turn, sometimes the whole field
	function automatic logic signed [15:0] rand_angle();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(25736)) - 12868);
	endfunction

	function automatic logic signed [16:0] rand_opening();
		case ($urandom_range(3))
			0: return 17'($urandom);
			1: return 17'($urandom_range(1) ? 32768 : 0);
			default: return 17'($urandom_range(32768));
		endcase
	endfunction

	initial begin
		sent            = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		joint_angle_1   = '0;
		joint_angle_2   = '0;
		joint_angle_3   = '0;
		joint_angle_4   = '0;
		gripper_opening = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero pose, field extremes, quarter turns, gripper clamping
		send_item(0, 0, 0, 0, 0);
		send_item(32767, 32767, 32767, 32767, 32768);
		send_item(-32768, -32768, -32768, -32768, 32768);
		send_item(32767, -32768, 32767, -32768, -65536);
		send_item(-32768, 32767, -32768, 32767, 65535);
		send_item(6434, 0, 0, 0, 16384);
		send_item(0, 6434, 0, 0, 16384);
		send_item(0, 0, 6434, 0, 16384);
		send_item(0, 0, 0, 6434, 16384);
		send_item(-6434, -6434, 12868, -12868, -1);
		send_item(12868, 12868, 12868, 12868, 32769);
		send_item(3217, -3217, 3217, -3217, 32767);
		send_item(3216, -3218, -1, 1, 1);
		send_item(-1, -1, -1, -1, 0);
		send_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 17'h0AAAA);
		send_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 17'h15555);

		// random items with idle bursts, none in the last part
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i < RAND_ITEMS - 200 && $urandom_range(4) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(11, 1)) @(posedge clk);
			end
			send_item(rand_angle(), rand_angle(), rand_angle(), rand_angle(),
				rand_opening());
		end
		start <= 1'b0;

		// drain
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d items: angle extremes, quarter turns, gripper clamping,",
			sent);
		$display("random joint vectors with idle bursts, %0d cycles", cycles);
		if (errors == 0) begin
			$display("tb_arm_forward_kinematics_unit: done, clean");
		end else begin
			$display("tb_arm_forward_kinematics_unit: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/afk_pkg.sv
rtl/afk_sincos.sv
rtl/afk_link.sv
rtl/arm_forward_kinematics_unit.sv
tb/afk_pose_checker.sv
tb/tb_arm_forward_kinematics_unit.sv
